// ----- src/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is low
`define SDSD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked check, also live during reset
`define SDSD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SDSD_ASSERT(name, prop, msg)
`define SDSD_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ----- src/sdsd_pkg.sv -----
// shared constants, types and segment tables of the signed decimal display driver
package sdsd_pkg;

  localparam int unsigned NUM_DIGITS_DEF = 6;
  localparam int unsigned POSITIONS      = 6;
  localparam int unsigned MAG_W          = 32;
  localparam int unsigned BIT_CNT_W      = 5;
  localparam int unsigned POS_W          = 3;
  localparam int unsigned SEG_W          = 8;
  localparam int unsigned LEN_W          = 3;
  localparam logic [SEG_W-1:0] SIGN_SEG  = 8'h04;

  typedef struct packed {
    logic             load;
    logic             check;
    logic             shift;
    logic [POS_W-1:0] pos;
  } sdsd_cmd_t;

  function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'hFC;
      4'd1: s = 8'h60;
      4'd2: s = 8'hDB;
      4'd3: s = 8'hF3;
      4'd4: s = 8'h67;
      4'd5: s = 8'hB7;
      4'd6: s = 8'hBF;
      4'd7: s = 8'hE4;
      4'd8: s = 8'hFF;
      4'd9: s = 8'hF7;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // letters i, n, f on positions 1..3
  function automatic logic [SEG_W-1:0] inf_main(input logic [POS_W-1:0] k);
    logic [SEG_W-1:0] s;
    case (k)
      3'd0: s = 8'h90;
      3'd1: s = 8'h6C;
      3'd2: s = 8'h8F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [SEG_W-1:0] inf_extra(input logic [POS_W-1:0] k);
    logic [SEG_W-1:0] s;
    case (k)
      3'd0: s = 8'h50;
      3'd1: s = 8'h82;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // elaboration-time power of ten
  function automatic logic [MAG_W-1:0] pow10(input int unsigned n);
    logic [MAG_W-1:0] p;
    p = 32'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 32'd10;
    end
    return p;
  endfunction

endpackage

// ----- src/sdsd_ctrl.sv -----
// sequencer: load, 32 shift-add steps, then six position beats
module sdsd_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  output logic                            strobe_o,
  output logic [sdsd_pkg::POS_W-1:0]      position_o,
  output logic                            last_o,
  output sdsd_pkg::sdsd_cmd_t             cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                             state_q, state_d;
  logic [sdsd_pkg::BIT_CNT_W-1:0]     bit_cnt_q, bit_cnt_d;
  logic [sdsd_pkg::POS_W-1:0]         pos_q, pos_d;

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    pos_d     = pos_q;
    cmd_o     = '0;
    cmd_o.pos = pos_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          bit_cnt_d  = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        cmd_o.check = (bit_cnt_q == '0);
        bit_cnt_d   = bit_cnt_q + 1'b1;
        if (bit_cnt_q == sdsd_pkg::BIT_CNT_W'(sdsd_pkg::MAG_W - 1)) begin
          pos_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pos_q == sdsd_pkg::POS_W'(sdsd_pkg::POSITIONS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      pos_q     <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      pos_q     <= pos_d;
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign strobe_o   = (state_q == ST_EMIT);
  assign position_o = pos_q + 1'b1;
  assign last_o     = strobe_o && (pos_q == sdsd_pkg::POS_W'(sdsd_pkg::POSITIONS - 1));

endmodule

// ----- src/sdsd_dpath.sv -----
// magnitude, double-dabble bcd register and segment selection
module sdsd_dpath #(
  parameter int unsigned NUM_DIGITS = sdsd_pkg::NUM_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic signed [31:0]              value_i,
  input  sdsd_pkg::sdsd_cmd_t             cmd_i,
  output logic [sdsd_pkg::SEG_W-1:0]      main_segments_o,
  output logic [sdsd_pkg::SEG_W-1:0]      extra_segments_o
);

  localparam int unsigned LIMIT =
    (NUM_DIGITS < sdsd_pkg::POSITIONS) ? NUM_DIGITS : sdsd_pkg::POSITIONS;
  localparam int unsigned BCD_W = 4 * LIMIT;
  localparam logic [sdsd_pkg::MAG_W-1:0] OVER = sdsd_pkg::pow10(LIMIT);

  logic [sdsd_pkg::MAG_W-1:0] mag_q, raw;
  logic [BCD_W-1:0]           bcd_q, bcd_adj;
  logic                       neg_q, inf_q;
  logic [sdsd_pkg::LEN_W-1:0] len;
  logic                       hit;
  logic [3:0]                 sel_dig;

  assign raw = $unsigned(value_i);

  // add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    for (int unsigned j = 0; j < LIMIT; j++) begin
      bcd_adj[j*4 +: 4] = (bcd_q[j*4 +: 4] >= 4'd5) ? bcd_q[j*4 +: 4] + 4'd3
                                                     : bcd_q[j*4 +: 4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= raw[sdsd_pkg::MAG_W-1];
      mag_q <= raw[sdsd_pkg::MAG_W-1] ? (~raw + 1'b1) : raw;
      bcd_q <= '0;
    end else if (cmd_i.shift) begin
      mag_q <= {mag_q[sdsd_pkg::MAG_W-2:0], 1'b0};
      bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[sdsd_pkg::MAG_W-1]};
    end
    if (cmd_i.check) begin
      inf_q <= (mag_q >= OVER);
    end
  end

  // digit count: highest nonzero digit, at least one
  always_comb begin
    len = sdsd_pkg::LEN_W'(1);
    for (int unsigned j = 1; j < LIMIT; j++) begin
      if (bcd_q[j*4 +: 4] != 4'd0) begin
        len = sdsd_pkg::LEN_W'(j + 1);
      end
    end
  end

  // left-aligned digit for this position
  always_comb begin
    hit     = 1'b0;
    sel_dig = 4'd0;
    for (int unsigned j = 0; j < LIMIT; j++) begin
      if ((4'(cmd_i.pos) + 4'(j) + 4'd1) == 4'(len)) begin
        hit     = 1'b1;
        sel_dig = bcd_q[j*4 +: 4];
      end
    end
  end

  always_comb begin
    if (inf_q) begin
      main_segments_o  = sdsd_pkg::inf_main(cmd_i.pos);
      extra_segments_o = sdsd_pkg::inf_extra(cmd_i.pos);
    end else begin
      main_segments_o  = hit ? sdsd_pkg::digit_seg(sel_dig) : '0;
      extra_segments_o = (neg_q && (cmd_i.pos == '0)) ? sdsd_pkg::SIGN_SEG : '0;
    end
  end

endmodule

// ----- src/signed_decimal_segment_display.sv -----
// top level of the signed decimal seven-segment display driver
//
//   channel   dir  handshake              payload
//   command   in   start_i, busy_o        value_i
//   result    out  strobe_o (no stall)    position_o, main_segments_o,
//                                         extra_segments_o, last_o
//
// a command beat is taken when start_i is high and busy_o is low
// the value loads at that edge, then the double-dabble loop shifts in all 32 magnitude bits,
// then six result beats on consecutive cycles, positions 1 to 6
// rst_ni clears only the sequencer; busy_o is low right after reset
// result beats cannot be held off, so busy_o alone throttles the sender
module signed_decimal_segment_display #(
  parameter int unsigned NUM_DIGITS = sdsd_pkg::NUM_DIGITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [31:0]              value_i,
  output logic                            strobe_o,
  output logic [sdsd_pkg::POS_W-1:0]      position_o,
  output logic [sdsd_pkg::SEG_W-1:0]      main_segments_o,
  output logic [sdsd_pkg::SEG_W-1:0]      extra_segments_o,
  output logic                            last_o
);

  `include "assert_macros.svh"

  // commands from the sequencer to the datapath
  sdsd_pkg::sdsd_cmd_t cmd;

  sdsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .strobe_o   (strobe_o),
    .position_o (position_o),
    .last_o     (last_o),
    .cmd_o      (cmd)
  );

  // magnitude and bcd digits live here; too-long values turn into i n f
  sdsd_dpath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .value_i          (value_i),
    .cmd_i            (cmd),
    .main_segments_o  (main_segments_o),
    .extra_segments_o (extra_segments_o)
  );

  `SDSD_ASSERT(a_strobe_busy, strobe_o |-> busy_o, "result beat while idle")
  `SDSD_ASSERT(a_first_pos, $rose(strobe_o) |-> position_o == 3'd1, "first beat not position 1")
  `SDSD_ASSERT(a_pos_step,
               (strobe_o && !last_o) |=> (strobe_o && (position_o == $past(position_o) + 3'd1)),
               "beats not consecutive")
  `SDSD_ASSERT(a_last_pos,
               last_o |-> (strobe_o && (position_o == 3'(sdsd_pkg::POSITIONS))),
               "last beat misplaced")
  `SDSD_ASSERT(a_busy_start, $rose(busy_o) |-> $past(start_i), "busy without a command beat")

endmodule
